@@ rtl/core/aminv_pkg.sv @@
// Shared constants, types and state encodings for the affine 3x4 matrix inverse.
package aminv_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int NUM_IN     = 12;
  localparam int IN_TDATA_W = NUM_IN * DATA_W;
  localparam int OUT_TDATA_W = 136;
  localparam int ROW_W      = 2;
  localparam int ADJ_W      = 65;
  localparam int ACC_W      = 99;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int QB         = DATA_W + 1;
  localparam int CNT_W      = $clog2(QB);
  localparam int DSH_W      = ACC_W + QB - 1;
  localparam int NUM_W      = ACC_W + FRAC_BITS;
  localparam int QDEPTH     = 2;
  localparam int NUM_ADJ    = 9;
  localparam int NUM_ROWS   = 3;
  localparam int NUM_LANES  = 4;

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(NUM_ROWS - 1);
  localparam logic [DATA_W-1:0] ONE_FX   = DATA_W'(1) << FRAC_BITS;

  // One decomposed matrix: 3x3 adjugate, translation adjugate and determinant.
  typedef struct packed {
    logic [NUM_ADJ-1:0][ADJ_W-1:0]  adj;
    logic [NUM_ROWS-1:0][ACC_W-1:0] tr;
    logic [ACC_W-1:0]               det;
  } aminv_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } aminv_qstat_t;

  typedef enum logic [1:0] {F_IDLE, F_RUN, F_WAIT} front_state_e;
  typedef enum logic [1:0] {PH_ADJ, PH_DET, PH_TR} phase_e;
  typedef enum logic [1:0] {DST_ADJ, DST_DET, DST_TR} dst_e;
  typedef enum logic [1:0] {B_START, B_DIV, B_EMIT} back_state_e;

endpackage

@@ rtl/core/aminv_front.sv @@
// Front end: input staging and the multiply-accumulate sequencer for adjugate and determinant.
module aminv_front import aminv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  aminv_qstat_t          qstat_i,
  output logic                  push_o,
  output aminv_job_t            job_o
);

  typedef struct packed {
    logic              sh;
    logic              neg;
    logic              first;
    logic              last;
    dst_e              dst;
    logic [3:0]        di;
  } step_t;

  // Cofactor product pairs: adj = m[P]*m[Q] - m[R]*m[S].
  localparam logic [3:0] ADJ_P [NUM_ADJ] = '{4'd5, 4'd2, 4'd1, 4'd6, 4'd0, 4'd2, 4'd4, 4'd1, 4'd0};
  localparam logic [3:0] ADJ_Q [NUM_ADJ] = '{4'd10, 4'd9, 4'd6, 4'd8, 4'd10, 4'd4, 4'd9, 4'd8, 4'd5};
  localparam logic [3:0] ADJ_R [NUM_ADJ] = '{4'd6, 4'd1, 4'd2, 4'd4, 4'd2, 4'd0, 4'd5, 4'd0, 4'd1};
  localparam logic [3:0] ADJ_S [NUM_ADJ] = '{4'd9, 4'd10, 4'd5, 4'd10, 4'd8, 4'd6, 4'd8, 4'd9, 4'd4};

  logic [IN_TDATA_W-1:0] stg_q;
  logic                  stg_full_q, stg_full_d;
  logic [DATA_W-1:0]     m_q [NUM_IN];
  logic [ADJ_W-1:0]      adj_q [NUM_ADJ];
  logic [ACC_W-1:0]      det_q;
  logic [ACC_W-1:0]      tr_q [NUM_ROWS];

  front_state_e state_q, state_d;
  phase_e       ph_q, ph_d;
  logic [3:0]   idx_q, idx_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic         hf_q, hf_d;

  logic [MUL_W-1:0]  x_d, y_d, x_q, y_q;
  step_t             c_d, c1_q, c2_q;
  logic              v1_q, v2_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q, acc_d, term;
  logic [3:0]        xi, yi, ai;
  logic              start, issue_last;

  assign s_axis_tready = !stg_full_q;
  assign start         = (state_q == F_IDLE) && stg_full_q;

  always_comb begin
    stg_full_d = stg_full_q;
    if (s_axis_tvalid && s_axis_tready) begin
      stg_full_d = 1'b1;
    end else if (start) begin
      stg_full_d = 1'b0;
    end
  end

  // Operand selection for the current step.
  always_comb begin
    xi = '0;
    yi = '0;
    ai = '0;
    x_d = '0;
    y_d = '0;
    c_d = '{sh: 1'b0, neg: 1'b0, first: 1'b0, last: 1'b0, dst: DST_ADJ, di: '0};
    case (ph_q)
      PH_ADJ: begin
        xi = hf_q ? ADJ_R[idx_q] : ADJ_P[idx_q];
        yi = hf_q ? ADJ_S[idx_q] : ADJ_Q[idx_q];
        x_d = {m_q[xi][DATA_W-1], m_q[xi]};
        y_d = {m_q[yi][DATA_W-1], m_q[yi]};
        c_d = '{sh: 1'b0, neg: hf_q, first: !hf_q, last: hf_q, dst: DST_ADJ, di: idx_q};
      end
      PH_DET: begin
        ai  = 4'(idx_q * 3);
        yi  = idx_q;
        x_d = hf_q ? adj_q[ai][ADJ_W-1:DATA_W] : {1'b0, adj_q[ai][DATA_W-1:0]};
        y_d = {m_q[yi][DATA_W-1], m_q[yi]};
        c_d = '{sh: hf_q, neg: 1'b0, first: (idx_q == 4'd0) && !hf_q,
                last: (idx_q == 4'd2) && hf_q, dst: DST_DET, di: '0};
      end
      PH_TR: begin
        ai  = 4'(row_q * 3 + idx_q);
        yi  = 4'(idx_q * 4 + 3);
        x_d = hf_q ? adj_q[ai][ADJ_W-1:DATA_W] : {1'b0, adj_q[ai][DATA_W-1:0]};
        y_d = {m_q[yi][DATA_W-1], m_q[yi]};
        c_d = '{sh: hf_q, neg: 1'b1, first: (idx_q == 4'd0) && !hf_q,
                last: (idx_q == 4'd2) && hf_q, dst: DST_TR, di: 4'(row_q)};
      end
      default: begin
        x_d = '0;
      end
    endcase
  end

  assign issue_last = (ph_q == PH_TR) && (row_q == LAST_ROW) && (idx_q == 4'd2) && hf_q;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    idx_d   = idx_q;
    row_d   = row_q;
    hf_d    = hf_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (start) begin
          state_d = F_RUN;
          ph_d    = PH_ADJ;
          idx_d   = '0;
          row_d   = '0;
          hf_d    = 1'b0;
        end
      end
      F_RUN: begin
        hf_d = !hf_q;
        if (hf_q) begin
          idx_d = idx_q + 4'd1;
          case (ph_q)
            PH_ADJ: begin
              if (idx_q == 4'(NUM_ADJ - 1)) begin
                ph_d  = PH_DET;
                idx_d = '0;
              end
            end
            PH_DET: begin
              if (idx_q == 4'd2) begin
                ph_d  = PH_TR;
                idx_d = '0;
                row_d = '0;
              end
            end
            PH_TR: begin
              if (idx_q == 4'd2) begin
                idx_d = '0;
                row_d = row_q + ROW_W'(1);
              end
            end
            default: begin
              ph_d = PH_ADJ;
            end
          endcase
        end
        if (issue_last) begin
          state_d = F_WAIT;
        end
      end
      F_WAIT: begin
        // Drain the fetch and multiply stages, then hand the job over.
        if (!v1_q && !v2_q && !qstat_i.full) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign term  = c2_q.sh ? (ACC_W'($signed(prod_q)) << DATA_W) : ACC_W'($signed(prod_q));
  assign acc_d = (c2_q.first ? '0 : acc_q) + (c2_q.neg ? (~term + ACC_W'(1)) : term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      stg_full_q <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      ph_q       <= PH_ADJ;
      idx_q      <= '0;
      row_q      <= '0;
      hf_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      stg_full_q <= stg_full_d;
      v1_q       <= (state_q == F_RUN);
      v2_q       <= v1_q;
      ph_q       <= ph_d;
      idx_q      <= idx_d;
      row_q      <= row_d;
      hf_q       <= hf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stg_q <= s_axis_tdata;
    end
    if (start) begin
      for (int i = 0; i < NUM_IN; i++) begin
        m_q[i] <= stg_q[i*DATA_W +: DATA_W];
      end
    end
    x_q    <= x_d;
    y_q    <= y_d;
    c1_q   <= c_d;
    prod_q <= PROD_W'($signed(x_q) * $signed(y_q));
    c2_q   <= c1_q;
    if (v2_q) begin
      acc_q <= acc_d;
      if (c2_q.last) begin
        case (c2_q.dst)
          DST_ADJ: adj_q[c2_q.di] <= acc_d[ADJ_W-1:0];
          DST_DET: det_q <= acc_d;
          DST_TR:  tr_q[c2_q.di[ROW_W-1:0]] <= acc_d;
          default: det_q <= acc_d;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_ADJ; i++) begin
      job_o.adj[i] = adj_q[i];
    end
    for (int i = 0; i < NUM_ROWS; i++) begin
      job_o.tr[i] = tr_q[i];
    end
    job_o.det = det_q;
  end

endmodule

@@ rtl/core/aminv_fifo.sv @@
// Two-entry job queue between the front end and the divider back end.
module aminv_fifo import aminv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  aminv_job_t   din_i,
  input  logic         pop_i,
  output aminv_job_t   dout_o,
  output aminv_qstat_t stat_o
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  aminv_job_t         mem_q [QDEPTH];
  logic [PTR_W-1:0]   wp_q, rp_q;
  logic [CNT_QW-1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == CNT_QW'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign dout_o       = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PTR_W'(QDEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PTR_W'(QDEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_QW'(push_i) - CNT_QW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= din_i;
    end
  end

endmodule

@@ rtl/core/aminv_div.sv @@
// One restoring-division lane with round-to-nearest and 32-bit saturation.
module aminv_div import aminv_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic              step_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic              neg_i,
  input  logic [DSH_W-1:0]  dsh_i,
  input  logic [ACC_W-1:0]  dabs_i,
  output logic [DATA_W-1:0] quo_o,
  output logic              sat_o
);

  logic [NUM_W-1:0]  rem_q;
  logic [QB-1:0]     q_q;
  logic              ovf_q, neg_q;
  logic [DSH_W-1:0]  rem_ext, diff;
  logic              ge, rnd;
  logic [QB:0]       qr, lim;
  logic [DATA_W-1:0] mag;

  assign rem_ext = DSH_W'(rem_q);
  assign ge      = rem_ext >= dsh_i;
  assign diff    = rem_ext - dsh_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= num_i;
      q_q   <= '0;
      neg_q <= neg_i;
      // Quotient would need more than QB bits: clip outright.
      ovf_q <= ((DSH_W + 1)'(num_i) >= {dabs_i, {QB{1'b0}}});
    end else if (step_i) begin
      if (ge) begin
        rem_q <= diff[NUM_W-1:0];
      end
      q_q <= {q_q[QB-2:0], ge};
    end
  end

  assign rnd   = {rem_q, 1'b0} >= (NUM_W + 1)'(dabs_i);
  assign qr    = (QB + 1)'(q_q) + (QB + 1)'(rnd);
  assign lim   = neg_q ? ((QB + 1)'(1) << (DATA_W - 1)) : (((QB + 1)'(1) << (DATA_W - 1)) - 1'b1);
  assign sat_o = ovf_q || (qr > lim);
  assign mag   = sat_o ? lim[DATA_W-1:0] : qr[DATA_W-1:0];
  assign quo_o = neg_q ? (~mag + DATA_W'(1)) : mag;

endmodule

@@ rtl/core/aminv_back.sv @@
// Back end: per-row division of the adjugate by the determinant and result register.
module aminv_back import aminv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aminv_job_t             job_i,
  input  aminv_qstat_t           qstat_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  back_state_e state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DSH_W-1:0] dsh_q;
  logic [ACC_W-1:0] dabs;
  logic             sing, load, step, take;
  logic [NUM_LANES-1:0][DATA_W-1:0] quo, res;
  logic [NUM_LANES-1:0]             lsat;
  logic [NUM_LANES-1:0][NUM_W-1:0]  num;
  logic [NUM_LANES-1:0]             nneg;

  logic                               ov_q;
  logic [ROW_W-1:0]                   orow_q;
  logic [NUM_LANES-1:0][DATA_W-1:0]   oc_q;
  logic                               osing_q, osat_q, olast_q;

  assign sing = (job_i.det == '0);
  assign dabs = job_i.det[ACC_W-1] ? (~job_i.det + ACC_W'(1)) : job_i.det;

  for (genvar j = 0; j < NUM_LANES - 1; j++) begin : g_adj
    logic [ADJ_W-1:0] a, amag;
    assign a       = job_i.adj[4'(row_q * 3 + j)];
    assign amag    = a[ADJ_W-1] ? (~a + ADJ_W'(1)) : a;
    assign num[j]  = NUM_W'({amag, {(2 * FRAC_BITS){1'b0}}});
    assign nneg[j] = a[ADJ_W-1] ^ job_i.det[ACC_W-1];
  end

  logic [ACC_W-1:0] t, tmag;
  assign t    = job_i.tr[row_q];
  assign tmag = t[ACC_W-1] ? (~t + ACC_W'(1)) : t;
  assign num[NUM_LANES-1]  = {tmag, {FRAC_BITS{1'b0}}};
  assign nneg[NUM_LANES-1] = t[ACC_W-1] ^ job_i.det[ACC_W-1];

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    aminv_div u_div (
      .clk_i  (clk_i),
      .load_i (load),
      .step_i (step),
      .num_i  (num[j]),
      .neg_i  (nneg[j]),
      .dsh_i  (dsh_q),
      .dabs_i (dabs),
      .quo_o  (quo[j]),
      .sat_o  (lsat[j])
    );
    assign res[j] = sing ? ((row_q == ROW_W'(j)) ? ONE_FX : '0) : quo[j];
  end

  assign take = !ov_q || m_axis_tready;
  assign load = (state_q == B_START) && !qstat_i.empty && !sing;
  assign step = (state_q == B_DIV);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    case (state_q)
      B_START: begin
        if (!qstat_i.empty) begin
          cnt_d   = CNT_W'(QB - 1);
          state_d = sing ? B_EMIT : B_DIV;
        end
      end
      B_DIV: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (take) begin
          state_d = B_START;
          if (row_q == LAST_ROW) begin
            row_d = '0;
            pop_o = 1'b1;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end
      end
      default: begin
        state_d = B_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_START;
      row_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      if ((state_q == B_EMIT) && take) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dsh_q <= {dabs, {(QB - 1){1'b0}}};
    end else if (step) begin
      dsh_q <= dsh_q >> 1;
    end
    if ((state_q == B_EMIT) && take) begin
      orow_q  <= row_q;
      oc_q    <= res;
      osing_q <= sing;
      osat_q  <= !sing && (|lsat);
      olast_q <= (row_q == LAST_ROW);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_TDATA_W'({oc_q, orow_q});
  assign m_axis_tuser  = {osat_q, osing_q};
  assign m_axis_tlast  = olast_q;

endmodule

@@ rtl/core/affine_matrix_inverse_3x4.sv @@
// A matrix passes the front-end multiply-accumulate, then one division for each result row.
// Each row division runs 33 steps in four parallel lanes;
//   a singular matrix skips the division and leaves the back end as identity rows.
// The front end works on the next matrix while the back end divides the current one.
// Reset (rst_ni low, asynchronous) empties the staging register, the queue and the output.
// Payload registers are not reset and hold no meaning until loaded.
module affine_matrix_inverse_3x4 import aminv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request in. tdata from bit 0: a00 a01 a02 a03 a10 a11 a12 a13 a20 a21 a22 a23,
  // 32 bits each, signed Q16.16.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result rows out. tdata from bit 0: row_index (2), out_c0, out_c1, out_c2,
  // out_c3 (32 each, signed Q16.16), then zero padding to 136 bits.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser from bit 0: singular, saturated.
  output logic [1:0]             m_axis_tuser,
  // tlast marks the third row of a matrix.
  output logic                   m_axis_tlast
);

  // The front end forms all nine 3x3 cofactors with one 33x33 multiplier,
  // then the determinant and the translation column from them in split
  // 32-bit halves. Each finished request goes through a small queue.
  aminv_job_t   fjob, bjob;
  aminv_qstat_t qstat;
  logic         push, pop;

  aminv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .qstat_i       (qstat),
    .push_o        (push),
    .job_o         (fjob)
  );

  aminv_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (fjob),
    .pop_i  (pop),
    .dout_o (bjob),
    .stat_o (qstat)
  );

  // The back end divides four entries of one row in parallel lanes and
  // holds the finished row in an output register, so the next row is
  // divided while the current one waits to be taken.
  aminv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (bjob),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The last row of a matrix always carries row index two.
  a_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == LAST_ROW)
    else $error("last row flag on a row other than two");

  // Identity rows for a singular matrix are never flagged as clipped.
  a_sing_nosat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("singular row reported as saturated");

  // The queue is never written while full nor read while empty.
  a_queue_safe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full) && !(pop && qstat.empty))
    else $error("job queue overflow or underflow");

endmodule
